// ----- rtl/calint_pkg.sv -----
// Package for the calibration curve interpolator: sizes, status codes,
// sequencer step and opcode codes, and the read-only microcode table.
// No dependencies.
`default_nettype none

package calint_pkg;

  // Curve geometry.
  localparam int CAL_POINTS = 8;
  localparam int REG_COUNT  = 8;
  localparam int IDX_W      = $clog2(REG_COUNT);
  localparam int ADDR_W     = IDX_W + 2;

  localparam logic [31:0] REG_RESET = 32'hF000_0000;
  localparam logic [15:0] Q_MINUS_ONE = 16'hF000;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAL_POINTS - 1);

  // Divider sizing: product magnitude fits 32 bits, two quotient bits a step.
  localparam int MAG_W   = 32;
  localparam int DEN_W   = 17;
  localparam int DIV_ITERS = MAG_W / 2;
  localparam int CNT_W   = $clog2(DIV_ITERS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_ITERS - 1);

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NEG   = 2'd1,
    ST_NOSEG = 2'd2,
    ST_ZERO  = 2'd3
  } status_t;

  // Sequencer step addresses.
  typedef logic [3:0] step_t;
  localparam step_t STEP_WAIT  = 4'd0;
  localparam step_t STEP_CHECK = 4'd1;
  localparam step_t STEP_SCAN  = 4'd2;
  localparam step_t STEP_LOAD  = 4'd3;
  localparam step_t STEP_MUL   = 4'd4;
  localparam step_t STEP_PREP  = 4'd5;
  localparam step_t STEP_DIV   = 4'd6;
  localparam step_t STEP_FIX   = 4'd7;
  localparam step_t STEP_ERR   = 4'd8;

  // Datapath operations selected by a control word.
  typedef enum logic [3:0] {
    OP_WAIT  = 4'd0,
    OP_CHECK = 4'd1,
    OP_SCAN  = 4'd2,
    OP_LOAD  = 4'd3,
    OP_MUL   = 4'd4,
    OP_PREP  = 4'd5,
    OP_DIV   = 4'd6,
    OP_FIX   = 4'd7,
    OP_ERR   = 4'd8
  } op_t;

  // One control word: the operation, the fall-through step and the branch
  // target. An error branch always goes to the error step.
  typedef struct packed {
    op_t   op;
    step_t next;
    step_t jump;
  } ctrl_t;

  // Microcode table.
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    case (s)
      STEP_WAIT:  w = '{op: OP_WAIT,  next: STEP_WAIT,  jump: STEP_CHECK};
      STEP_CHECK: w = '{op: OP_CHECK, next: STEP_SCAN,  jump: STEP_SCAN};
      STEP_SCAN:  w = '{op: OP_SCAN,  next: STEP_SCAN,  jump: STEP_LOAD};
      STEP_LOAD:  w = '{op: OP_LOAD,  next: STEP_MUL,   jump: STEP_MUL};
      STEP_MUL:   w = '{op: OP_MUL,   next: STEP_PREP,  jump: STEP_PREP};
      STEP_PREP:  w = '{op: OP_PREP,  next: STEP_DIV,   jump: STEP_DIV};
      STEP_DIV:   w = '{op: OP_DIV,   next: STEP_DIV,   jump: STEP_FIX};
      STEP_FIX:   w = '{op: OP_FIX,   next: STEP_WAIT,  jump: STEP_WAIT};
      STEP_ERR:   w = '{op: OP_ERR,   next: STEP_WAIT,  jump: STEP_WAIT};
      default:    w = '{op: OP_WAIT,  next: STEP_WAIT,  jump: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/calibration_curve_interpolator.sv -----
// Calibration curve interpolator: microcoded sequencer, point scan, one
// multiply and a two-bit-per-step restoring divider. Depends on calint_pkg.
//
//  Channel   | Handshake                      | Payload
//  ----------+--------------------------------+------------------------------
//  input     | start, busy (start & !busy)    | absorbance
//  result    | done (one-cycle strobe)        | chlorine, status
//  config    | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// A negative input goes from the check step straight to the error result. The
// scan loop then visits the points in turn until one lies above the sample;
// meeting the end of the curve or running off the table gives an error result,
// as does a zero-width segment at the load step. A full result passes the load,
// multiply, prep, divider loop (16 steps) and fix steps. The result strobe comes
// in the cycle after the last step, and busy is already low then. rst is
// synchronous and restores all points to x = -1.0, y = 0. The receiver cannot
// stall; each result is shown for one cycle.
`default_nettype none

module calibration_curve_interpolator
  import calint_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic signed [15:0]  absorbance,
  output logic                     done,
  output logic signed [15:0]       chlorine,
  output logic [1:0]               status,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  // Calibration point registers.
  logic [31:0] cal [REG_COUNT];

  // Sequencer.
  step_t pc;
  ctrl_t cw;

  // Datapath registers.
  logic signed [15:0]      a_reg;
  logic [IDX_W-1:0]        idx;
  logic signed [15:0]      x0, y0, x1, y1;
  logic signed [DEN_W-1:0] dx, dy, den;
  logic signed [33:0]      prod;
  logic [MAG_W-1:0]        quo;
  logic [DEN_W-1:0]        rem, dmag;
  logic                    neg;
  logic [CNT_W-1:0]        cnt;
  status_t                 err_st;

  // Combinational helpers.
  logic signed [15:0]  cur_x, cur_y;
  logic [DEN_W:0]      t1, t2;
  logic                ge1, ge2;
  logic [DEN_W-1:0]    r1, r2;
  logic signed [33:0]  q_signed, sum;
  logic signed [33:0]  prod_abs;
  logic signed [DEN_W-1:0] den_abs;

  assign cw     = ucode(pc);
  assign busy   = (pc != STEP_WAIT);
  assign pready = 1'b1;
  assign prdata = cal[paddr[ADDR_W-1:2]];

  // Point under test in the scan loop.
  assign cur_x = signed'(cal[idx][31:16]);
  assign cur_y = signed'(cal[idx][15:0]);

  // Two restoring division steps per cycle.
  assign t1  = {rem, quo[MAG_W-1]};
  assign ge1 = (t1 >= {1'b0, dmag});
  assign r1  = ge1 ? DEN_W'(t1 - {1'b0, dmag}) : t1[DEN_W-1:0];
  assign t2  = {r1, quo[MAG_W-2]};
  assign ge2 = (t2 >= {1'b0, dmag});
  assign r2  = ge2 ? DEN_W'(t2 - {1'b0, dmag}) : t2[DEN_W-1:0];

  // Magnitudes for the divider setup.
  assign prod_abs = prod[33] ? -prod : prod;
  assign den_abs  = den[DEN_W-1] ? -den : den;

  // Sign fixup of the quotient and offset by y0.
  assign q_signed = neg ? -signed'({2'b00, quo}) : signed'({2'b00, quo});
  assign sum      = q_signed + 34'(y0);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        cal[i] <= REG_RESET;
      end
    end else if (psel && penable && pwrite && pready) begin
      cal[paddr[ADDR_W-1:2]] <= pwdata;
    end
  end

  // Sequencer step counter and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= STEP_WAIT;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (cw.op)
        OP_WAIT: begin
          pc <= start ? cw.jump : cw.next;
        end
        OP_CHECK: begin
          pc <= a_reg[15] ? STEP_ERR : cw.next;
        end
        OP_SCAN: begin
          if (cur_x == signed'(Q_MINUS_ONE)) begin
            pc <= STEP_ERR;
          end else if (cur_x > a_reg) begin
            pc <= cw.jump;
          end else if (idx == LAST_IDX) begin
            pc <= STEP_ERR;
          end else begin
            pc <= cw.next;
          end
        end
        OP_LOAD: begin
          pc <= (x1 == x0) ? STEP_ERR : cw.next;
        end
        OP_DIV: begin
          pc <= (cnt == CNT_LAST) ? cw.jump : cw.next;
        end
        OP_FIX, OP_ERR: begin
          pc   <= cw.next;
          done <= 1'b1;
        end
        default: begin
          pc <= cw.next;
        end
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    unique case (cw.op)
      OP_WAIT: begin
        if (start) begin
          a_reg <= absorbance;
        end
      end
      OP_CHECK: begin
        err_st <= ST_NEG;
        idx    <= IDX_W'(1);
        x0     <= signed'(cal[0][31:16]);
        y0     <= signed'(cal[0][15:0]);
      end
      OP_SCAN: begin
        // Keep the point before the one under test in x0/y0.
        err_st <= ST_NOSEG;
        x1     <= cur_x;
        y1     <= cur_y;
        if (!(cur_x > a_reg)) begin
          x0  <= cur_x;
          y0  <= cur_y;
          idx <= idx + IDX_W'(1);
        end
      end
      OP_LOAD: begin
        err_st <= ST_ZERO;
        dx     <= DEN_W'(a_reg) - DEN_W'(x0);
        dy     <= DEN_W'(y1) - DEN_W'(y0);
        den    <= DEN_W'(x1) - DEN_W'(x0);
      end
      OP_MUL: begin
        prod <= dy * dx;
      end
      OP_PREP: begin
        quo  <= prod_abs[MAG_W-1:0];
        dmag <= den_abs;
        neg  <= prod[33] ^ den[DEN_W-1];
        rem  <= '0;
        cnt  <= '0;
      end
      OP_DIV: begin
        rem <= r2;
        quo <= {quo[MAG_W-3:0], ge1, ge2};
        cnt <= cnt + CNT_W'(1);
      end
      OP_FIX: begin
        status <= ST_OK;
        if (sum > 34'sd32767) begin
          chlorine <= 16'sh7FFF;
        end else if (sum < -34'sd32768) begin
          chlorine <= -16'sh8000;
        end else begin
          chlorine <= sum[15:0];
        end
      end
      OP_ERR: begin
        status   <= err_st;
        chlorine <= signed'(Q_MINUS_ONE);
      end
      default: begin
      end
    endcase
  end

  // A result strobe only follows a result-producing step.
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(pc) == STEP_FIX || $past(pc) == STEP_ERR))
    else $error("result strobe without a final step");

  // An error result always carries -1.0.
  a_err_val: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (chlorine == signed'(Q_MINUS_ONE)))
    else $error("error result with a value other than -1.0");

  // An accepted sample starts the program at its first step.
  a_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (pc == STEP_CHECK))
    else $error("accepted sample did not start the program");

  // The partial remainder stays below the divisor throughout the divide.
  a_rem: assert property (@(posedge clk) disable iff (rst)
    (pc == STEP_DIV) |-> (rem < dmag))
    else $error("divider remainder out of range");

  // The block is free again when a result is shown.
  a_free: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for calibration_curve_interpolator: a directed table, then random curves
// and random samples, checked against typed table values or a behavioral interpolator.
// Depends on calint_pkg and the RTL top level only.

module tb_top;
  import calint_pkg::*;

  // Register indexes of the calibration points.
  localparam logic [IDX_W-1:0] PT0 = 3'd0;
  localparam logic [IDX_W-1:0] PT1 = 3'd1;
  localparam logic [IDX_W-1:0] PT2 = 3'd2;
  localparam logic [IDX_W-1:0] PT3 = 3'd3;
  localparam logic [IDX_W-1:0] PT4 = 3'd4;
  localparam logic [IDX_W-1:0] PT5 = 3'd5;
  localparam logic [IDX_W-1:0] PT6 = 3'd6;
  localparam logic [IDX_W-1:0] PT7 = 3'd7;

  localparam int N_DIRECTED = 35;
  localparam int N_PHASES   = 12;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [15:0] chlorine;
    status_t     status;
  } reading_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef enum logic [2:0] {
    CURVE_ZEROS, CURVE_ONES, CURVE_MAXPOS, CURVE_RANDOM, CURVE_MONO
  } curve_kind_t;

  // One directed step: a sample (word[15:0]) or a point write (idx, word).
  typedef struct packed {
    row_kind_t        kind;
    logic [IDX_W-1:0] idx;
    logic [31:0]      word;
    logic             typed;
    logic [15:0]      exp_chl;
    status_t          exp_st;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [15:0] absorbance = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic busy;
  logic done;
  logic signed [15:0] chlorine;
  logic [1:0] status;
  logic [31:0] prdata;
  logic pready;

  logic [31:0] cal_shadow [REG_COUNT];
  reading_t pending_readings [$];
  int failures = 0;

  calibration_curve_interpolator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .absorbance(absorbance),
    .done(done), .chlorine(chlorine), .status(status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("calibration_curve_interpolator verification failed");
    $finish;
  end

  // Directed table. Typed rows carry results that are obvious from the curve.
  row_t directed_rows [N_DIRECTED] = '{
    // Curve after reset: every point is an end marker.
    '{ROW_SAMPLE, PT0, 32'h0000_0000, 1'b1, Q_MINUS_ONE, ST_NOSEG},
    '{ROW_SAMPLE, PT0, 32'h0000_7FFF, 1'b1, Q_MINUS_ONE, ST_NOSEG},
    '{ROW_SAMPLE, PT0, 32'h0000_8000, 1'b1, Q_MINUS_ONE, ST_NEG},
    '{ROW_SAMPLE, PT0, 32'h0000_FFFF, 1'b1, Q_MINUS_ONE, ST_NEG},
    // A short rising curve ending at the largest x.
    '{ROW_WRITE,  PT0, 32'h0000_0000, 1'b0, 16'h0000, ST_OK},
    '{ROW_WRITE,  PT1, 32'h1000_1000, 1'b0, 16'h0000, ST_OK},
    '{ROW_WRITE,  PT2, 32'h2000_3000, 1'b0, 16'h0000, ST_OK},
    '{ROW_WRITE,  PT3, 32'h7FFF_7FFF, 1'b0, 16'h0000, ST_OK},
    '{ROW_SAMPLE, PT0, 32'h0000_0000, 1'b1, 16'h0000, ST_OK},
    '{ROW_SAMPLE, PT0, 32'h0000_0800, 1'b0, 16'h0000, ST_OK},
    '{ROW_SAMPLE, PT0, 32'h0000_1000, 1'b0, 16'h0000, ST_OK},
    '{ROW_SAMPLE, PT0, 32'h0000_7FFE, 1'b0, 16'h0000, ST_OK},
    '{ROW_SAMPLE, PT0, 32'h0000_7FFF, 1'b1, Q_MINUS_ONE, ST_NOSEG},
    // Zero-width first segment.
    '{ROW_WRITE,  PT0, 32'h1000_0000, 1'b0, 16'h0000, ST_OK},
    '{ROW_SAMPLE, PT0, 32'h0000_0064, 1'b1, Q_MINUS_ONE, ST_ZERO},
    // Falling segments extrapolated past both rails.
    '{ROW_WRITE,  PT0, 32'h7FFF_7FFF, 1'b0, 16'h0000, ST_OK},
    '{ROW_WRITE,  PT1, 32'h0001_8000, 1'b0, 16'h0000, ST_OK},
    '{ROW_SAMPLE, PT0, 32'h0000_0000, 1'b0, 16'h0000, ST_OK},
    '{ROW_WRITE,  PT0, 32'h7FFF_8000, 1'b0, 16'h0000, ST_OK},
    '{ROW_WRITE,  PT1, 32'h0001_7FFF, 1'b0, 16'h0000, ST_OK},
    '{ROW_SAMPLE, PT0, 32'h0000_0000, 1'b0, 16'h0000, ST_OK},
    // Point 0 holding x = -1.0 is an ordinary point.
    '{ROW_WRITE,  PT0, {Q_MINUS_ONE, 16'h0000}, 1'b0, 16'h0000, ST_OK},
    '{ROW_WRITE,  PT1, 32'h1000_1000, 1'b0, 16'h0000, ST_OK},
    '{ROW_SAMPLE, PT0, 32'h0000_0800, 1'b0, 16'h0000, ST_OK},
    // End marker at point 1.
    '{ROW_WRITE,  PT1, {Q_MINUS_ONE, 16'h1234}, 1'b0, 16'h0000, ST_OK},
    '{ROW_SAMPLE, PT0, 32'h0000_0000, 1'b1, Q_MINUS_ONE, ST_NOSEG},
    // Full table with no end marker, then a sample past its last point.
    '{ROW_WRITE,  PT1, 32'h0400_0100, 1'b0, 16'h0000, ST_OK},
    '{ROW_WRITE,  PT2, 32'h0800_0200, 1'b0, 16'h0000, ST_OK},
    '{ROW_WRITE,  PT3, 32'h0C00_0300, 1'b0, 16'h0000, ST_OK},
    '{ROW_WRITE,  PT4, 32'h1000_0400, 1'b0, 16'h0000, ST_OK},
    '{ROW_WRITE,  PT5, 32'h1400_0500, 1'b0, 16'h0000, ST_OK},
    '{ROW_WRITE,  PT6, 32'h1800_0600, 1'b0, 16'h0000, ST_OK},
    '{ROW_WRITE,  PT7, 32'h1C00_0700, 1'b0, 16'h0000, ST_OK},
    '{ROW_SAMPLE, PT0, 32'h0000_7000, 1'b1, Q_MINUS_ONE, ST_NOSEG},
    '{ROW_SAMPLE, PT0, 32'h0000_1800, 1'b0, 16'h0000, ST_OK}
  };

  // Expected reading for one sample under the current curve.
  function automatic reading_t interpolate_chlorine(input logic signed [15:0] a);
    reading_t res;
    int seg;
    int xi, x0, x1, y0, y1;
    bit stop;
    longint num, q, r;
    res.chlorine = Q_MINUS_ONE;
    seg = 0;
    stop = 1'b0;
    if (a < 0) begin
      res.status = ST_NEG;
      return res;
    end
    // Find the first point after point 0 whose x lies above the sample.
    for (int i = 1; i < CAL_POINTS && !stop; i++) begin
      xi = $signed(cal_shadow[i][31:16]);
      if (cal_shadow[i][31:16] == Q_MINUS_ONE) begin
        stop = 1'b1;
      end else if (xi > a) begin
        seg = i;
        stop = 1'b1;
      end
    end
    if (seg == 0) begin
      res.status = ST_NOSEG;
      return res;
    end
    x0 = $signed(cal_shadow[seg-1][31:16]);
    y0 = $signed(cal_shadow[seg-1][15:0]);
    x1 = $signed(cal_shadow[seg][31:16]);
    y1 = $signed(cal_shadow[seg][15:0]);
    if (x1 == x0) begin
      res.status = ST_ZERO;
      return res;
    end
    // Exact product, quotient truncated toward zero, then saturation.
    num = longint'(y1 - y0) * longint'(int'(a) - x0);
    q = num / longint'(x1 - x0);
    r = q + y0;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    res.chlorine = r[15:0];
    res.status = ST_OK;
    return res;
  endfunction

  // Present one sample and hold it until the transfer happens.
  task automatic send_sample(input logic [15:0] a, input bit typed, input reading_t given);
    start <= 1'b1;
    absorbance <= a;
    do @(posedge clk); while (busy);
    if (typed) pending_readings.push_back(given);
    else pending_readings.push_back(interpolate_chlorine(a));
  endtask

  // Stop sending and let every outstanding reading come back.
  task automatic settle();
    start <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // Register write: setup cycle, access cycle, then idle with psel low.
  task automatic write_point(input logic [IDX_W-1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    cal_shadow[idx] = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Register read, compared with the value last written.
  task automatic check_point(input logic [IDX_W-1:0] idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== cal_shadow[idx]) begin
      $display("%0t: point %0d read back: expected %h, actual %h",
               $time, idx, cal_shadow[idx], prdata);
      failures++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write a whole curve of the given kind and read it back.
  task automatic load_curve(input curve_kind_t kind);
    int n, x, k;
    logic [31:0] w;
    n = $urandom_range(2, CAL_POINTS);
    x = $urandom_range(0, 4000);
    for (int i = 0; i < REG_COUNT; i++) begin
      case (kind)
        CURVE_ZEROS:  w = 32'h0000_0000;
        CURVE_ONES:   w = 32'hFFFF_FFFF;
        CURVE_MAXPOS: w = 32'h7FFF_7FFF;
        CURVE_RANDOM: w = $urandom();
        default: begin
          // Mostly rising x, with some flat and falling steps.
          if (i >= n) begin
            w = {Q_MINUS_ONE, 16'($urandom())};
          end else begin
            if (i > 0) begin
              k = $urandom_range(0, 9);
              if (k == 1) x -= int'($urandom_range(1, 3000));
              else if (k != 0) x += int'($urandom_range(1, 9000));
              if (x < 0) x = 0;
              if (x > 32767) x = 32767;
            end
            w = {16'(x), 16'($urandom())};
          end
        end
      endcase
      write_point(IDX_W'(i), w);
    end
    for (int i = 0; i < REG_COUNT; i++) check_point(IDX_W'(i));
  endtask

  // Each result strobe is one transfer, matched against the oldest expectation.
  always @(posedge clk) begin
    reading_t want;
    if (done) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected reading chlorine=%h status=%0d",
                 $time, chlorine, status);
        failures++;
      end else begin
        want = pending_readings.pop_front();
        if (chlorine !== want.chlorine) begin
          $display("%0t: chlorine: expected %h, actual %h",
                   $time, want.chlorine, chlorine);
          failures++;
        end
        if (status !== want.status) begin
          $display("%0t: status: expected %0d, actual %0d",
                   $time, want.status, status);
          failures++;
        end
      end
    end
  end

  initial begin
    int n_items, gap_odds, span, pick, xv;
    logic [15:0] a;
    curve_kind_t kind;
    foreach (cal_shadow[i]) cal_shadow[i] = REG_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part.
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        settle();
        write_point(directed_rows[r].idx, directed_rows[r].word);
      end else begin
        send_sample(directed_rows[r].word[15:0], directed_rows[r].typed,
                    '{chlorine: directed_rows[r].exp_chl, status: directed_rows[r].exp_st});
      end
    end

    // Random part: a fresh curve per phase, the last phase without gaps.
    for (int phase = 0; phase < N_PHASES; phase++) begin
      settle();
      case (phase)
        0: kind = CURVE_ZEROS;
        1: kind = CURVE_ONES;
        2: kind = CURVE_MAXPOS;
        3, 4: kind = CURVE_RANDOM;
        default: kind = CURVE_MONO;
      endcase
      load_curve(kind);
      n_items = (phase < 3) ? 40 : (phase < 5) ? 80 : 100;
      gap_odds = (phase == N_PHASES - 1) ? 0 : $urandom_range(0, 4);

      // Span of sample values that land inside the curve.
      span = 64;
      for (int i = 0; i < REG_COUNT; i++) begin
        xv = $signed(cal_shadow[i][31:16]);
        if (xv + 64 > span) span = xv + 64;
      end
      if (span > 32767) span = 32767;

      for (int s = 0; s < n_items; s++) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          a = 16'($urandom());
        end else if (pick < 18) begin
          a = 16'h8000 | 16'($urandom());
        end else if (pick < 35) begin
          // On a point's x or one step either side of it.
          xv = $signed(cal_shadow[$urandom_range(0, REG_COUNT - 1)][31:16]);
          a = 16'(xv + int'($urandom_range(0, 2)) - 1);
        end else begin
          a = 16'($urandom_range(0, span));
        end
        send_sample(a, 1'b0, '{chlorine: 16'h0000, status: ST_OK});
        if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 19)) @(posedge clk);
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("calibration_curve_interpolator verification clean");
    end else begin
      $display("calibration_curve_interpolator verification failed");
    end
    $finish;
  end

endmodule
